// File: design/utf8s_pkg.sv
// Package for the UTF-8 character segmenter: byte-class constants, the count limit,
// the result-group struct passed from decoder to emitter, and small helper functions.
// No dependencies.
package utf8s_pkg;

    // String length bound; counts stop at min(MAX_STRING_BYTES - 1, 65535).
    localparam longint unsigned MAX_STRING_BYTES = 64'd65536;
    localparam logic [15:0] COUNT_LIMIT = (MAX_STRING_BYTES > 64'd65536) ? 16'hFFFF
                                        : 16'(MAX_STRING_BYTES - 64'd1);

    // Byte class masks and tags
    localparam logic [7:0] MASK_ASCII = 8'h80;
    localparam logic [7:0] MASK_LEAD2 = 8'hE0;
    localparam logic [7:0] MASK_CONT  = 8'hC0;
    localparam logic [7:0] MASK_LEAD3 = 8'hF0;
    localparam logic [7:0] MASK_LEAD4 = 8'hF8;
    localparam logic [7:0] TAG_CONT   = 8'h80;
    localparam logic [7:0] TAG_LEAD2  = 8'hC0;
    localparam logic [7:0] TAG_LEAD3  = 8'hE0;
    localparam logic [7:0] TAG_LEAD4  = 8'hF0;

    // ASCII whitespace codes
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_SPACE = 8'h20;

    // Lead byte lengths; zero marks a byte that cannot start a character
    localparam logic [2:0] LEN_BAD = 3'd0;
    localparam logic [2:0] LEN_ONE = 3'd1;
    localparam logic [2:0] LEN_TWO = 3'd2;
    localparam logic [2:0] LEN_THR = 3'd3;
    localparam logic [2:0] LEN_FOU = 3'd4;

    // Results caused by one input byte: flushed held bytes, then an optional final char
    typedef struct packed {
        logic [2:0][7:0] held;
        logic [1:0]      nflush;
        logic [15:0]     cur;
        logic            final_vld;
        logic [31:0]     final_bytes;
        logic [2:0]      final_len;
        logic [15:0]     final_start;
        logic            final_bad;
        logic            final_space;
        logic            last;
    } t_grp;

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        priority if ((b & MASK_ASCII) == 8'h00)      len = LEN_ONE;
        else if ((b & MASK_LEAD2) == TAG_LEAD2)      len = LEN_TWO;
        else if ((b & MASK_LEAD3) == TAG_LEAD3)      len = LEN_THR;
        else if ((b & MASK_LEAD4) == TAG_LEAD4)      len = LEN_FOU;
        else                                         len = LEN_BAD;
        return len;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b & MASK_CONT) == TAG_CONT;
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CHR_SPACE) || (b == CHR_TAB) || (b == CHR_LF) || (b == CHR_CR);
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v >= COUNT_LIMIT) ? COUNT_LIMIT : v + 16'd1;
    endfunction

endpackage

// File: design/utf8_char_segmenter.sv
// UTF-8 character segmenter, top level: input handshake, decoder and result emitter.
// Depends on utf8s_pkg, utf8s_decode and utf8s_emit.
//
// Feed a string one byte per item, setting i_last_byte on its final byte; the block
// returns one item per UTF-8 character with its bytes packed from bit 31 down, its
// length, start position, running character index and malformed/whitespace flags.
// A lead byte that is not valid, a sequence broken by a non-continuation byte, or a
// string that ends inside a sequence turns each affected byte into a malformed
// one-byte character; scanning resumes at the breaking byte. The last result of a
// string carries o_last_char, and all counters restart at zero for the next string.
// Positions and indexes saturate at 65535. Rate: one byte is accepted per cycle
// while each byte yields at most one character and the output is not stalled. A byte
// that yields several characters (up to 4, only on malformed input) holds the result
// emitter until all are out, since the emitter hands out one character per cycle
// while the output is not stalled; bytes that only extend a sequence yield nothing.
// An accepted byte's first character passes a group register after the decoder, then
// the output register. The output register lets a new byte enter while a result waits.
module utf8_char_segmenter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_byte_value,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_char_bytes,
    output logic [2:0]  o_char_len,
    output logic [15:0] o_char_start,
    output logic [15:0] o_char_index,
    output logic        o_malformed,
    output logic        o_is_space,
    output logic        o_last_char
);
    import utf8s_pkg::*;

    logic in_accept;
    logic grp_load;
    logic grp_free;
    t_grp grp;

    // Take a byte whenever the group register is empty or drains this cycle.
    assign o_in_ready = grp_free;
    assign in_accept  = i_in_valid && grp_free;

    utf8s_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_byte_value (i_byte_value),
        .i_last_byte  (i_last_byte),
        .o_grp_load   (grp_load),
        .o_grp        (grp)
    );

    utf8s_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_grp_load   (grp_load),
        .i_grp        (grp),
        .o_grp_free   (grp_free),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_char_bytes (o_char_bytes),
        .o_char_len   (o_char_len),
        .o_char_start (o_char_start),
        .o_char_index (o_char_index),
        .o_malformed  (o_malformed),
        .o_is_space   (o_is_space),
        .o_last_char  (o_last_char)
    );

endmodule

// File: design/utf8s_decode.sv
// Byte decoder for the UTF-8 character segmenter: holds the unfinished sequence and
// the byte position, and turns each accepted byte into at most one result group.
// Depends on utf8s_pkg.
module utf8s_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_byte_value,
    input  logic            i_last_byte,
    output logic            o_grp_load,
    output utf8s_pkg::t_grp o_grp
);
    import utf8s_pkg::*;

    logic [2:0][7:0] r_pend, n_pend;
    logic [1:0]      r_pcnt, n_pcnt;
    logic [2:0]      r_exp, n_exp;
    logic [15:0]     r_pos, n_pos;
    logic [2:0]      lead;
    logic            hold;
    logic [31:0]     packed_chr;

    assign lead = lead_len(i_byte_value);
    assign hold = (r_pcnt != 2'd0);

    always_comb begin
        unique case (r_pcnt)
            2'd1:    packed_chr = {r_pend[0], i_byte_value, 16'h0000};
            2'd2:    packed_chr = {r_pend[0], r_pend[1], i_byte_value, 8'h00};
            2'd3:    packed_chr = {r_pend[0], r_pend[1], r_pend[2], i_byte_value};
            default: packed_chr = {i_byte_value, 24'h000000};
        endcase
    end

    always_comb begin
        n_pend = r_pend;
        n_pcnt = r_pcnt;
        n_exp  = r_exp;
        n_pos  = i_last_byte ? 16'd0 : sat_inc(r_pos);

        o_grp             = '0;
        o_grp.held        = r_pend;
        o_grp.cur         = r_pos;
        o_grp.final_bytes = {i_byte_value, 24'h000000};
        o_grp.final_len   = 3'd1;
        o_grp.final_start = r_pos;
        o_grp.last        = i_last_byte;

        if (hold && is_cont(i_byte_value)) begin
            if (({1'b0, r_pcnt} + 3'd1) >= r_exp) begin
                // sequence complete
                o_grp.final_vld   = 1'b1;
                o_grp.final_bytes = packed_chr;
                o_grp.final_len   = {1'b0, r_pcnt} + 3'd1;
                o_grp.final_start = (r_pos >= 16'(r_pcnt)) ? r_pos - 16'(r_pcnt) : 16'd0;
                n_pcnt = 2'd0;
                n_exp  = 3'd0;
            end else if (i_last_byte) begin
                // string cut off inside a sequence
                o_grp.nflush    = r_pcnt;
                o_grp.final_vld = 1'b1;
                o_grp.final_bad = 1'b1;
                n_pcnt = 2'd0;
                n_exp  = 3'd0;
            end else begin
                n_pend[r_pcnt] = i_byte_value;
                n_pcnt = r_pcnt + 2'd1;
            end
        end else begin
            // flush whatever is held, then treat the byte as a lead byte
            o_grp.nflush = r_pcnt;
            n_pcnt = 2'd0;
            n_exp  = 3'd0;
            if (lead == LEN_ONE) begin
                o_grp.final_vld   = 1'b1;
                o_grp.final_space = is_ws(i_byte_value);
            end else if ((lead == LEN_BAD) || i_last_byte) begin
                o_grp.final_vld = 1'b1;
                o_grp.final_bad = 1'b1;
            end else begin
                n_pend[0] = i_byte_value;
                n_pcnt = 2'd1;
                n_exp  = lead;
            end
        end

        if (i_last_byte) begin
            n_pcnt = 2'd0;
            n_exp  = 3'd0;
        end
    end

    assign o_grp_load = i_accept && ((o_grp.nflush != 2'd0) || o_grp.final_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt <= 2'd0;
            r_exp  <= 3'd0;
            r_pos  <= 16'd0;
        end else if (i_accept) begin
            r_pcnt <= n_pcnt;
            r_exp  <= n_exp;
            r_pos  <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_pend <= n_pend;
        end
    end

endmodule

// File: design/utf8s_emit.sv
// Result emitter for the UTF-8 character segmenter: holds one result group and hands
// its characters, numbered, out one per cycle unless stalled, through a registered output.
// Depends on utf8s_pkg.
module utf8s_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_grp_load,
    input  utf8s_pkg::t_grp i_grp,
    output logic            o_grp_free,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [31:0]     o_char_bytes,
    output logic [2:0]      o_char_len,
    output logic [15:0]     o_char_start,
    output logic [15:0]     o_char_index,
    output logic            o_malformed,
    output logic            o_is_space,
    output logic            o_last_char
);
    import utf8s_pkg::*;

    t_grp        r_grp;
    logic        r_grp_vld;
    logic [1:0]  r_slot;
    logic [15:0] r_cnt;
    logic        r_out_vld;
    logic [31:0] r_bytes;
    logic [2:0]  r_len;
    logic [15:0] r_start;
    logic [15:0] r_index;
    logic        r_bad;
    logic        r_space;
    logic        r_last;

    logic        out_load;
    logic        slot_final;
    logic        grp_end;
    logic [1:0]  back;
    logic [7:0]  held_byte;
    logic [31:0] n_bytes;
    logic [2:0]  n_len;
    logic [15:0] n_start;
    logic        n_bad;
    logic        n_space;
    logic        n_last;

    assign out_load   = r_grp_vld && (!r_out_vld || i_out_ready);
    assign slot_final = (r_slot == r_grp.nflush);
    assign grp_end    = slot_final
                     || (!r_grp.final_vld && (2'(r_slot + 2'd1) == r_grp.nflush));
    assign o_grp_free = !r_grp_vld || (out_load && grp_end);
    assign back       = r_grp.nflush - r_slot;

    always_comb begin
        unique case (r_slot)
            2'd0:    held_byte = r_grp.held[0];
            2'd1:    held_byte = r_grp.held[1];
            default: held_byte = r_grp.held[2];
        endcase
    end

    always_comb begin
        if (slot_final) begin
            n_bytes = r_grp.final_bytes;
            n_len   = r_grp.final_len;
            n_start = r_grp.final_start;
            n_bad   = r_grp.final_bad;
            n_space = r_grp.final_space;
            n_last  = r_grp.last;
        end else begin
            n_bytes = {held_byte, 24'h000000};
            n_len   = 3'd1;
            n_start = (r_grp.cur >= 16'(back)) ? r_grp.cur - 16'(back) : 16'd0;
            n_bad   = 1'b1;
            n_space = 1'b0;
            n_last  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_vld <= 1'b0;
            r_slot    <= 2'd0;
            r_cnt     <= 16'd0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_grp_load) begin
                r_grp_vld <= 1'b1;
                r_slot    <= 2'd0;
            end else if (out_load && grp_end) begin
                r_grp_vld <= 1'b0;
            end else if (out_load) begin
                r_slot <= r_slot + 2'd1;
            end

            if (out_load) begin
                r_out_vld <= 1'b1;
                r_cnt     <= n_last ? 16'd0 : sat_inc(r_cnt);
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_grp_load) begin
            r_grp <= i_grp;
        end
        if (out_load) begin
            r_bytes <= n_bytes;
            r_len   <= n_len;
            r_start <= n_start;
            r_index <= r_cnt;
            r_bad   <= n_bad;
            r_space <= n_space;
            r_last  <= n_last;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_char_bytes = r_bytes;
    assign o_char_len   = r_len;
    assign o_char_start = r_start;
    assign o_char_index = r_index;
    assign o_malformed  = r_bad;
    assign o_is_space   = r_space;
    assign o_last_char  = r_last;

endmodule

// File: design/utf8s_checker.sv
// Port-level checks for the UTF-8 character segmenter, bound to the top level.
// Depends on utf8s_pkg and utf8_char_segmenter.
module utf8s_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_last_byte,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_char_bytes,
    input logic [2:0]  o_char_len,
    input logic [15:0] o_char_index,
    input logic        o_malformed,
    input logic        o_is_space,
    input logic        o_last_char
);
    import utf8s_pkg::*;

    logic        out_acc;
    logic [15:0] r_exp_idx;

    assign out_acc = o_out_valid && i_out_ready;

    // Track the index the next result must carry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_idx <= 16'd0;
        end else if (out_acc) begin
            r_exp_idx <= o_last_char ? 16'd0 : sat_inc(r_exp_idx);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_char_bytes)
            && $stable(o_char_index) && $stable(o_last_char))
        else $error("result changed while stalled");

    a_index_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> o_char_index == r_exp_idx)
        else $error("character index out of sequence");

    a_malformed_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_malformed || o_is_space) |->
            o_char_len == 3'd1 && o_char_bytes[23:0] == 24'h000000)
        else $error("flagged character is not a single byte");

    a_space_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_space |-> !o_malformed && !o_char_bytes[31])
        else $error("whitespace flag on a non-ASCII byte");

    // The final byte passes the group register, then the output register.
    a_last_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_last_byte |=> ##1 o_out_valid)
        else $error("final byte produced no result");

endmodule

bind utf8_char_segmenter utf8s_checker u_utf8s_checker (.*);

// File: test/utf8_char_checker.sv
`timescale 1ns / 100ps
// Result checker for utf8_char_segmenter: watches both handshakes, predicts the
// characters each accepted byte yields and compares them in order. Uses utf8s_pkg.
module utf8_char_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_byte_value,
    input  logic        i_last_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_char_bytes,
    input  logic [2:0]  i_char_len,
    input  logic [15:0] i_char_start,
    input  logic [15:0] i_char_index,
    input  logic        i_malformed,
    input  logic        i_is_space,
    input  logic        i_last_char,
    output int          o_fail_count,
    output int          o_outstanding,
    output int          o_checked
);
    import utf8s_pkg::*;

    typedef struct packed {
        logic [31:0] bytes;
        logic [2:0]  len;
        logic [15:0] start;
        logic [15:0] idx;
        logic        bad;
        logic        space;
        logic        tail;
    } t_char_rec;

    t_char_rec   expected_chars[$];
    t_char_rec   fresh[4];
    int          fresh_n;
    logic [7:0]  held_bytes[3];
    int          held_cnt;
    int          want_len;
    logic [15:0] byte_pos;
    logic [15:0] char_cnt;

    function automatic logic [15:0] bump_count(input logic [15:0] v);
        return (v < COUNT_LIMIT) ? v + 16'd1 : v;
    endfunction

    function automatic int lead_span(input logic [7:0] b);
        casez (b)
            8'b0???????: return 1;
            8'b110?????: return 2;
            8'b1110????: return 3;
            8'b11110???: return 4;
            default:     return 0;
        endcase
    endfunction

    // Held bytes start back from the current (possibly saturated) position.
    function automatic logic [15:0] held_start(input logic [15:0] cur, input int k);
        int back;
        back = held_cnt - k;
        return (cur >= back) ? cur - 16'(back) : 16'd0;
    endfunction

    task automatic add_char(input logic [31:0] bytes, input logic [2:0] len,
                            input logic [15:0] start, input logic bad, input logic space);
        fresh[fresh_n] = {bytes, len, start, char_cnt, bad, space, 1'b0};
        fresh_n++;
        char_cnt = bump_count(char_cnt);
    endtask

    task automatic flush_held(input logic [15:0] cur);
        int k;
        for (k = 0; k < held_cnt; k++)
            add_char({held_bytes[k], 24'h0}, 3'd1, held_start(cur, k), 1'b1, 1'b0);
        held_cnt = 0;
        want_len = 0;
    endtask

    task automatic segment_byte(input logic [7:0] b, input logic fin);
        logic [15:0] cur;
        logic [31:0] joined;
        logic        done;
        logic        space;
        t_char_rec   rec;
        int          span;
        int          k;
        cur = byte_pos;
        done = 1'b0;
        fresh_n = 0;
        if (held_cnt != 0) begin
            if (b[7:6] == 2'b10) begin
                if (held_cnt + 1 >= want_len) begin
                    joined = 32'h0;
                    for (k = 0; k < held_cnt; k++)
                        joined |= {held_bytes[k], 24'h0} >> (8 * k);
                    joined |= {b, 24'h0} >> (8 * held_cnt);
                    add_char(joined, 3'(held_cnt + 1), held_start(cur, 0), 1'b0, 1'b0);
                    held_cnt = 0;
                    want_len = 0;
                end else if (fin) begin
                    flush_held(cur);
                    add_char({b, 24'h0}, 3'd1, cur, 1'b1, 1'b0);
                end else begin
                    held_bytes[held_cnt] = b;
                    held_cnt++;
                end
                done = 1'b1;
            end else begin
                flush_held(cur);
            end
        end
        if (!done) begin
            span = lead_span(b);
            if (span == 1) begin
                space = (b == CHR_SPACE) || (b == CHR_TAB) || (b == CHR_LF) || (b == CHR_CR);
                add_char({b, 24'h0}, 3'd1, cur, 1'b0, space);
            end else if (span == 0 || fin) begin
                add_char({b, 24'h0}, 3'd1, cur, 1'b1, 1'b0);
            end else begin
                held_bytes[0] = b;
                held_cnt = 1;
                want_len = span;
            end
        end
        byte_pos = bump_count(cur);
        if (fin) begin
            // the final character of a string carries the tail flag
            if (fresh_n > 0) begin
                rec = fresh[fresh_n - 1];
                rec.tail = 1'b1;
                fresh[fresh_n - 1] = rec;
            end
            held_cnt = 0;
            want_len = 0;
            byte_pos = 16'd0;
            char_cnt = 16'd0;
        end
        for (k = 0; k < fresh_n; k++)
            expected_chars.push_back(fresh[k]);
    endtask

    task automatic check_char();
        t_char_rec got;
        t_char_rec want;
        got = {i_char_bytes, i_char_len, i_char_start, i_char_index,
               i_malformed, i_is_space, i_last_char};
        o_checked++;
        if (expected_chars.size() == 0) begin
            o_fail_count++;
            $display("%0t: unexpected char: bytes=%h len=%0d start=%0d index=%0d",
                     $time, got.bytes, got.len, got.start, got.idx);
        end else begin
            want = expected_chars.pop_front();
            if (got !== want) begin
                o_fail_count++;
                $display({"%0t: char mismatch: expected bytes=%h len=%0d start=%0d ",
                          "idx=%0d bad=%b sp=%b last=%b, actual bytes=%h len=%0d ",
                          "start=%0d idx=%0d bad=%b sp=%b last=%b"},
                         $time, want.bytes, want.len, want.start, want.idx, want.bad,
                         want.space, want.tail, got.bytes, got.len, got.start, got.idx,
                         got.bad, got.space, got.tail);
            end
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_outstanding = 0;
        o_checked = 0;
        held_cnt = 0;
        want_len = 0;
        byte_pos = 16'd0;
        char_cnt = 16'd0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_chars.delete();
            held_cnt = 0;
            want_len = 0;
            byte_pos = 16'd0;
            char_cnt = 16'd0;
        end else begin
            if (i_in_valid && i_in_ready)
                segment_byte(i_byte_value, i_last_byte);
            if (i_out_valid && i_out_ready)
                check_char();
        end
        o_outstanding = expected_chars.size();
    end

endmodule

// File: test/utf8_char_segmenter_test.sv
`timescale 1ns / 100ps
// Top of the utf8_char_segmenter testbench: clock, reset, byte stimulus and the
// random output stall. Depends on utf8s_pkg, utf8_char_segmenter and utf8_char_checker.
module utf8_char_segmenter_test;
    import utf8s_pkg::*;

    localparam int HOLD_CYCLES = 200;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_byte_value;
    logic        i_last_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_char_bytes;
    logic [2:0]  o_char_len;
    logic [15:0] o_char_start;
    logic [15:0] o_char_index;
    logic        o_malformed;
    logic        o_is_space;
    logic        o_last_char;

    int          fail_count;
    int          outstanding;
    int          checked;

    // stimulus bookkeeping and idling controls
    logic [7:0]  str_bytes[$];
    int          bytes_sent;
    int          strings_sent;
    logic        src_idle_on;
    logic        sink_idle_on;
    logic        sink_hold_req;

    utf8_char_segmenter DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_byte_value (i_byte_value),
        .i_last_byte  (i_last_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_char_bytes (o_char_bytes),
        .o_char_len   (o_char_len),
        .o_char_start (o_char_start),
        .o_char_index (o_char_index),
        .o_malformed  (o_malformed),
        .o_is_space   (o_is_space),
        .o_last_char  (o_last_char)
    );

    utf8_char_checker CHECK (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_byte_value  (i_byte_value),
        .i_last_byte   (i_last_byte),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_char_bytes  (o_char_bytes),
        .i_char_len    (o_char_len),
        .i_char_start  (o_char_start),
        .i_char_index  (o_char_index),
        .i_malformed   (o_malformed),
        .i_is_space    (o_is_space),
        .i_last_char   (o_last_char),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    // Output side: random stall bursts, or a long hold-off when asked for.
    // All changes land on the falling edge so the rising edge sees stable values.
    initial begin : sink
        int stall;
        stall = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_req) begin
                // hold off long enough that the block backs up into its input
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                sink_hold_req = 1'b0;
            end else if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 19) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic logic [7:0] lead_of(input int span);
        case (span)
            2:       return {3'b110, 5'($urandom)};
            3:       return {4'b1110, 4'($urandom)};
            default: return {5'b11110, 3'($urandom)};
        endcase
    endfunction

    // Append one character to the string under construction. Most are well
    // formed with random payload bits; the rest are stray bytes or sequences
    // cut short, so the recovery paths get exercised with random neighbors.
    task automatic push_random_char();
        int kind;
        int span;
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            case ($urandom_range(0, 3))
                0:       str_bytes.push_back(CHR_SPACE);
                1:       str_bytes.push_back(CHR_TAB);
                2:       str_bytes.push_back(CHR_LF);
                default: str_bytes.push_back(CHR_CR);
            endcase
        end else if (kind < 6) begin
            str_bytes.push_back({1'b0, 7'($urandom)});
        end else if (kind < 15) begin
            span = 2 + (kind - 6) / 3;
            str_bytes.push_back(lead_of(span));
            repeat (span - 1) str_bytes.push_back({2'b10, 6'($urandom)});
        end else if (kind < 18) begin
            // stray byte of any value, often a bad lead
            str_bytes.push_back(8'($urandom));
        end else begin
            // truncated sequence: whatever follows breaks it
            span = $urandom_range(2, 4);
            str_bytes.push_back(lead_of(span));
            repeat ($urandom_range(0, span - 2)) str_bytes.push_back({2'b10, 6'($urandom)});
        end
    endtask

    // Offer one byte and hold it until the block takes it. A random idle burst
    // may come first; valid is only ever driven once per falling edge.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (src_idle_on && $urandom_range(0, 7) == 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_byte_value <= b;
        i_last_byte  <= fin;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Send the string under construction, flagging its last byte.
    task automatic send_queued();
        int k;
        for (k = 0; k < str_bytes.size(); k++)
            send_byte(str_bytes[k], k == str_bytes.size() - 1);
        str_bytes.delete();
        strings_sent++;
    endtask

    task automatic send_random_strings(input int nbytes);
        int target;
        target = bytes_sent + nbytes;
        while (bytes_sent < target) begin
            repeat ($urandom_range(1, 12)) push_random_char();
            send_queued();
        end
    endtask

    // Drop valid and wait for every predicted character to come out.
    task automatic drain_all();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    initial begin : stimulus
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_byte_value  = 8'h00;
        i_last_byte   = 1'b0;
        bytes_sent    = 0;
        strings_sent  = 0;
        src_idle_on   = 1'b1;
        sink_idle_on  = 1'b1;
        sink_hold_req = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: whitespace and the ASCII extremes
        str_bytes = '{CHR_SPACE, CHR_TAB, CHR_LF, CHR_CR, 8'h00, 8'h7F};
        send_queued();
        // two-, three- and four-byte sequences, the last one closing the string
        str_bytes = '{8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80};
        send_queued();
        // bad lead bytes, including the top of the byte range
        str_bytes = '{8'h80, 8'hFF, 8'hF8};
        send_queued();
        // four-byte sequence broken on its last byte: four characters at once
        str_bytes = '{8'hF0, 8'h9F, 8'h98, 8'h41};
        send_queued();
        // string ends inside a sequence on a continuation byte
        str_bytes = '{8'hE2, 8'h82};
        send_queued();
        // string ends right on a lead byte
        str_bytes = '{8'hC3};
        send_queued();
        drain_all();

        // Random strings with idling on both sides
        send_random_strings(60);

        // Stall the output for a long stretch while bytes keep coming
        src_idle_on = 1'b0;
        sink_hold_req = 1'b1;
        send_random_strings(40);
        src_idle_on = 1'b1;
        send_random_strings(100);
        drain_all();

        // A stretch with no idling at all, then idling again
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        send_random_strings(60);
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;
        send_random_strings(60);
        drain_all();

        // Last part: random strings, no idling
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        send_random_strings(120);
        drain_all();
        repeat (16) @(negedge i_clk);

        $display("Sent %0d strings, %0d bytes; checked %0d characters.",
                 strings_sent, bytes_sent, checked);
        $display("Exercised bad leads, broken and cut-off sequences and a long output stall.");
        if (fail_count == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
